// ===== design/saa_pkg.sv =====
// shared types, constants and codes of the shelf atlas allocator
package saa_pkg;

  localparam int MaxShelves = 64;
  localparam int MaxSide    = 4096;
  localparam int MinSide    = 16;
  localparam int ResetSide  = 128;

  localparam int IdxW = (MaxShelves > 1) ? $clog2(MaxShelves) : 1;
  localparam int CntW = $clog2(MaxShelves + 1);

  localparam int SideW = 13;
  localparam int PosW  = 12;
  localparam int DimW  = 10;
  localparam int RowHW = 11;

  // configuration register indexes
  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef enum logic [1:0] {
    StPlaced  = 2'd0,
    StDoubled = 2'd1,
    StFull    = 2'd2,
    StMaxPage = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CsIdle,
    CsScan,
    CsNewRow,
    CsResp
  } ctrl_state_e;

  typedef struct packed {
    logic            req_type;
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [SideW-1:0] atlas_width;
    logic [SideW-1:0] atlas_height;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic [PosW-1:0]  top;
    logic [RowHW-1:0] height;
    logic [SideW-1:0] used;
  } shelf_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    shelf_t          wr_data;
  } ram_req_t;

endpackage

// ===== design/shelf_atlas_allocator.sv =====
// top level of the shelf atlas allocator: config, control, shelf memory, output register
//
//   channel   direction  handshake                   payload
//   request   in         req_valid_i / req_ready_o   req_i   (saa_pkg::req_t)
//   response  out        rsp_valid_o / rsp_ready_i   rsp_o   (saa_pkg::rsp_t)
//   config    in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// an allocate request is accepted, reads and compares each stored shelf in turn through the
// single memory read port, tries to open a new shelf when none fits and then hands the
// result over; a hit ends the scan early and a clear goes straight to the result;
// reset empties the page at 128 x 128 with no clearing pass; the shelf memory is not reset
// one request is worked at a time; the next is taken while a result waits in the
// output register, and its result holds until that register frees up
module shelf_atlas_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  saa_pkg::req_t              req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output saa_pkg::rsp_t              rsp_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [saa_pkg::SideW-1:0]  cfg_wdata_i
);
  import saa_pkg::*;

  // configured page size, applied at the next clear
  logic [SideW-1:0] cfg_w_q, cfg_w_d;
  logic [SideW-1:0] cfg_h_q, cfg_h_d;

  ram_req_t ram_req;
  shelf_t   ram_rdata;
  rsp_t     res;
  logic     res_valid;
  logic     res_take;

  // output register
  logic out_vld_q, out_vld_d;
  rsp_t out_q, out_d;

  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxWidth:  cfg_w_d = cfg_wdata_i;
        CfgIdxHeight: cfg_h_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  saa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_i        (req_i),
    .req_ready_o  (req_ready_o),
    .cfg_width_i  (cfg_w_q),
    .cfg_height_i (cfg_h_q),
    .ram_o        (ram_req),
    .ram_rdata_i  (ram_rdata),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take)
  );

  saa_shelf_ram u_ram (
    .clk_i   (clk_i),
    .ram_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // result moves over when the register is empty or drains this cycle
  assign res_take = res_valid && (!out_vld_q || rsp_ready_i);

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (rsp_ready_i) out_vld_d = 1'b0;
    if (res_take) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= SideW'(ResetSide);
      cfg_h_q   <= SideW'(ResetSide);
      out_vld_q <= 1'b0;
    end else begin
      cfg_w_q   <= cfg_w_d;
      cfg_h_q   <= cfg_h_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

// ===== design/saa_shelf_ram.sv =====
// shelf table memory, one write and one registered read port
module saa_shelf_ram (
  input  logic              clk_i,
  input  saa_pkg::ram_req_t ram_i,
  output saa_pkg::shelf_t   rdata_o
);
  import saa_pkg::*;

  shelf_t mem_q [MaxShelves];
  shelf_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_i.wr_en) begin
      mem_q[ram_i.wr_addr] <= ram_i.wr_data;
    end
    if (ram_i.rd_en) begin
      rdata_q <= mem_q[ram_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/saa_ctrl.sv =====
// scan sequencer and page state of the shelf allocator
module saa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  saa_pkg::req_t              req_i,
  output logic                       req_ready_o,
  input  logic [saa_pkg::SideW-1:0]  cfg_width_i,
  input  logic [saa_pkg::SideW-1:0]  cfg_height_i,
  output saa_pkg::ram_req_t          ram_o,
  input  saa_pkg::shelf_t            ram_rdata_i,
  output saa_pkg::rsp_t              res_o,
  output logic                       res_valid_o,
  input  logic                       res_take_i
);
  import saa_pkg::*;

  ctrl_state_e state_q, state_d;
  req_t              req_q, req_d;
  logic [RowHW-1:0]  rowh_q, rowh_d;
  logic [CntW-1:0]   rd_cnt_q, rd_cnt_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SideW-1:0]  next_top_q, next_top_d;
  logic [SideW-1:0]  page_w_q, page_w_d;
  logic [SideW-1:0]  page_h_q, page_h_d;
  rsp_t              res_q, res_d;

  logic              accept;
  logic [17:0]       div_prod;
  logic [RowHW-1:0]  rowh_new;
  logic              rd_issue;
  logic [14:0]       h_x10, sh_x7;
  logic              fit;
  logic [SideW:0]    sum_top;
  logic              dbl, over, fail, full;
  logic [SideW-1:0]  nw, nh;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v < SideW'(MinSide)) r = SideW'(MinSide);
    else if ({1'b0, v} > (SideW+1)'(MaxSide)) r = SideW'(MaxSide);
    return r;
  endfunction

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == CsIdle);
  assign res_valid_o = (state_q == CsResp);
  assign res_o       = res_q;

  // h/10 as h*205 >> 11, exact for every 10-bit h
  assign div_prod = 18'(req_i.rect_height) * 18'd205;
  assign rowh_new = RowHW'(req_i.rect_height) + RowHW'(div_prod[17:11]);

  // first-fit test on the entry read last cycle
  assign rd_issue = (state_q == CsScan) && (rd_cnt_q < count_q);
  assign h_x10 = 15'(req_q.rect_height) * 15'd10;
  assign sh_x7 = 15'(ram_rdata_i.height) * 15'd7;
  assign fit = chk_vld_q && (h_x10 >= sh_x7) &&
               (RowHW'(req_q.rect_height) <= ram_rdata_i.height) &&
               ((14'(ram_rdata_i.used) + 14'(req_q.rect_width)) <= 14'(page_w_q));

  // new shelf decision
  assign full    = (count_q == CntW'(MaxShelves));
  assign sum_top = (SideW+1)'(next_top_q) + (SideW+1)'(rowh_q);
  assign dbl     = (sum_top >= (SideW+1)'(page_h_q)) ||
                   (SideW'(req_q.rect_width) >= page_w_q);
  assign over    = ({page_w_q, 1'b0} > (SideW+1)'(MaxSide)) ||
                   ({page_h_q, 1'b0} > (SideW+1)'(MaxSide));
  assign nw      = dbl ? {page_w_q[SideW-2:0], 1'b0} : page_w_q;
  assign nh      = dbl ? {page_h_q[SideW-2:0], 1'b0} : page_h_q;
  assign fail    = (sum_top > (SideW+1)'(nh)) || (SideW'(req_q.rect_width) > nw);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CsIdle: begin
        if (accept) state_d = req_i.req_type ? CsResp : CsScan;
      end
      CsScan: begin
        if (fit) state_d = CsResp;
        else if (!rd_issue) state_d = CsNewRow;
      end
      CsNewRow: state_d = CsResp;
      CsResp: begin
        if (res_take_i) state_d = CsIdle;
      end
      default: state_d = CsIdle;
    endcase
  end

  always_comb begin
    req_d      = req_q;
    rowh_d     = rowh_q;
    rd_cnt_d   = rd_cnt_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    count_d    = count_q;
    next_top_d = next_top_q;
    page_w_d   = page_w_q;
    page_h_d   = page_h_q;
    res_d      = res_q;
    ram_o      = '0;
    case (state_q)
      CsIdle: begin
        if (accept) begin
          req_d    = req_i;
          rowh_d   = rowh_new;
          rd_cnt_d = '0;
          if (req_i.req_type) begin
            count_d    = '0;
            next_top_d = '0;
            page_w_d   = clamp_side(cfg_width_i);
            page_h_d   = clamp_side(cfg_height_i);
            res_d      = '{pos_x: '0, pos_y: '0, atlas_width: clamp_side(cfg_width_i),
                           atlas_height: clamp_side(cfg_height_i), status: StPlaced};
          end
        end
      end
      CsScan: begin
        ram_o.rd_en   = rd_issue;
        ram_o.rd_addr = rd_cnt_q[IdxW-1:0];
        if (rd_issue) rd_cnt_d = rd_cnt_q + 1'b1;
        chk_vld_d = rd_issue && !fit;
        chk_idx_d = rd_cnt_q[IdxW-1:0];
        if (fit) begin
          ram_o.wr_en   = 1'b1;
          ram_o.wr_addr = chk_idx_q;
          ram_o.wr_data = '{top: ram_rdata_i.top, height: ram_rdata_i.height,
                            used: ram_rdata_i.used + SideW'(req_q.rect_width)};
          res_d = '{pos_x: ram_rdata_i.used[PosW-1:0], pos_y: ram_rdata_i.top,
                    atlas_width: page_w_q, atlas_height: page_h_q, status: StPlaced};
        end
      end
      CsNewRow: begin
        res_d = '{pos_x: '0, pos_y: '0, atlas_width: page_w_q,
                  atlas_height: page_h_q, status: StPlaced};
        if (full) begin
          res_d.status = StFull;
        end else if ((dbl && over) || fail) begin
          res_d.status = StMaxPage;
        end else begin
          ram_o.wr_en   = 1'b1;
          ram_o.wr_addr = count_q[IdxW-1:0];
          ram_o.wr_data = '{top: next_top_q[PosW-1:0], height: rowh_q,
                            used: SideW'(req_q.rect_width)};
          page_w_d   = nw;
          page_h_d   = nh;
          count_d    = count_q + 1'b1;
          next_top_d = sum_top[SideW-1:0];
          res_d = '{pos_x: '0, pos_y: next_top_q[PosW-1:0], atlas_width: nw,
                    atlas_height: nh, status: dbl ? StDoubled : StPlaced};
        end
      end
      CsResp: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CsIdle;
      chk_vld_q  <= 1'b0;
      rd_cnt_q   <= '0;
      count_q    <= '0;
      next_top_q <= '0;
      page_w_q   <= SideW'(ResetSide);
      page_h_q   <= SideW'(ResetSide);
    end else begin
      state_q    <= state_d;
      chk_vld_q  <= chk_vld_d;
      rd_cnt_q   <= rd_cnt_d;
      count_q    <= count_d;
      next_top_q <= next_top_d;
      page_w_q   <= page_w_d;
      page_h_q   <= page_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rowh_q    <= rowh_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
  end

`ifndef SYNTHESIS
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.wr_en |-> (state_q == CsScan || state_q == CsNewRow))
    else $error("shelf write outside scan or new row");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxShelves))
    else $error("shelf count above table size");
  a_top_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_top_q <= page_h_q)
    else $error("next top below page bottom");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type) |=> (count_q == '0 && next_top_q == '0))
    else $error("clear did not empty the page");
  a_scan_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.rd_en |-> (rd_cnt_q < count_q))
    else $error("read beyond stored shelves");
`endif

endmodule

// ===== tb/shelf_atlas_allocator_tb.sv =====
`timescale 1ns / 1ps
// testbench of the shelf atlas allocator: directed and random requests against a predictor
module shelf_atlas_allocator_tb;
  import saa_pkg::*;

  // request kinds carried in req_type
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqClear = 1'b1;

  // hold-off of the receiver in the long stall test, in cycles
  localparam int unsigned LongHoldCycles = 300;
  // generous ceiling on the simulation length, in cycles
  localparam int unsigned CycleLimit = 500000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 req_valid_i = 1'b0;
  logic                 req_ready_o;
  req_t                 req_i       = '0;
  logic                 rsp_valid_o;
  logic                 rsp_ready_i = 1'b0;
  rsp_t                 rsp_o;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_idx_i   = CfgIdxWidth;
  logic [SideW-1:0]     cfg_wdata_i = '0;

  // random idling on both channels, switched off for stretches and at the tail
  logic                 idle_on     = 1'b1;
  // flipped by a test to make the receiver hold off for a long stretch
  logic                 hold_tgl    = 1'b0;

  int unsigned          errors      = 0;
  int unsigned          reqs_sent   = 0;
  int unsigned          cycle_cnt   = 0;

  // results still owed by the block, oldest first
  rsp_t                 placements_due[$];

  // predicted allocator state: shelf rows, page and configured sides
  int unsigned          row_top    [MaxShelves];
  int unsigned          row_height [MaxShelves];
  int unsigned          row_fill   [MaxShelves];
  int unsigned          rows_open  = 0;
  int unsigned          free_top   = 0;
  int unsigned          cur_w      = ResetSide;
  int unsigned          cur_h      = ResetSide;
  int unsigned          cfg_w      = ResetSide;
  int unsigned          cfg_h      = ResetSide;

  shelf_atlas_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // first-fit placement of one request; updates the predicted state and
  // returns the result the block owes for it
  function automatic rsp_t place_rect(req_t r);
    rsp_t        res;
    int unsigned w, h, rh, nw, nh;
    logic        hit, grow;
    res = '0;
    res.status = StPlaced;
    w = 32'(r.rect_width);
    h = 32'(r.rect_height);
    if (r.req_type == ReqClear) begin
      // empty page at the configured size, sides clamped into the legal range
      rows_open = 0;
      free_top  = 0;
      cur_w = (cfg_w < MinSide) ? MinSide : (cfg_w > MaxSide) ? MaxSide : cfg_w;
      cur_h = (cfg_h < MinSide) ? MinSide : (cfg_h > MaxSide) ? MaxSide : cfg_h;
    end else begin
      hit = 1'b0;
      // a row takes the rectangle when 0.7 row height <= h <= row height and it has room
      for (int i = 0; i < rows_open && !hit; i++) begin
        if (10 * h >= 7 * row_height[i] && h <= row_height[i] &&
            row_fill[i] + w <= cur_w) begin
          hit = 1'b1;
          res.pos_x = PosW'(row_fill[i]);
          res.pos_y = PosW'(row_top[i]);
          row_fill[i] += w;
        end
      end
      if (!hit) begin
        if (rows_open >= MaxShelves) begin
          res.status = StFull;
        end else begin
          // new row with ten percent headroom; page doubles once when it runs short
          rh   = h + h / 10;
          grow = (free_top + rh >= cur_h) || (w >= cur_w);
          nw   = grow ? 2 * cur_w : cur_w;
          nh   = grow ? 2 * cur_h : cur_h;
          if (nw > MaxSide || nh > MaxSide || free_top + rh > nh || w > nw) begin
            res.status = StMaxPage;
          end else begin
            cur_w = nw;
            cur_h = nh;
            row_top[rows_open]    = free_top;
            row_height[rows_open] = rh;
            row_fill[rows_open]   = w;
            res.pos_y = PosW'(free_top);
            rows_open++;
            free_top += rh;
            res.status = grow ? StDoubled : StPlaced;
          end
        end
      end
    end
    res.atlas_width  = SideW'(cur_w);
    res.atlas_height = SideW'(cur_h);
    return res;
  endfunction

  function automatic req_t make_req(logic kind, int unsigned w, int unsigned h);
    req_t r;
    r.req_type    = kind;
    r.rect_width  = DimW'(w);
    r.rect_height = DimW'(h);
    return r;
  endfunction

  // random rectangle: mostly near the phase's row height so rows fill up,
  // some tiny ones and a few over the whole field range
  function automatic req_t rand_rect(int unsigned base);
    req_t r;
    r.req_type = ReqAlloc;
    case ($urandom_range(0, 9))
      0: begin
        r.rect_width  = DimW'($urandom_range(0, 1023));
        r.rect_height = DimW'($urandom_range(0, 1023));
      end
      1, 2, 3: begin
        r.rect_width  = DimW'($urandom_range(0, 40));
        r.rect_height = DimW'($urandom_range(0, 20));
      end
      default: begin
        r.rect_width  = DimW'($urandom_range(1, 160));
        r.rect_height = DimW'(base - $urandom_range(0, base * 3 / 10));
      end
    endcase
    return r;
  endfunction

  // page side for the config registers, extremes and out-of-range values included
  function automatic int unsigned pick_side();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 16;
      2:       return 4096;
      3:       return 8191;
      4:       return 128;
      5:       return 1024;
      6:       return $urandom_range(0, 8191);
      default: return $urandom_range(64, 4096);
    endcase
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (placements_due.size() == 0) begin
      errors++;
      $display("%0t: response with none expected, actual %p", $time, got);
      return;
    end
    want = placements_due.pop_front();
    cmp_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
    cmp_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
    cmp_field("atlas_width", 32'(want.atlas_width), 32'(got.atlas_width));
    cmp_field("atlas_height", 32'(want.atlas_height), 32'(got.atlas_height));
    cmp_field("status", 32'(want.status), 32'(got.status));
  endtask

  // receiver: checks each accepted result and drives ready, with short random
  // stalls and the long hold-off when a test asks for it
  logic        hold_seen  = 1'b0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) check_rsp(rsp_o);
      if (hold_tgl != hold_seen) begin
        hold_seen  = hold_tgl;
        stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        // short burst of random length: ready dropped now and held low while stall_left runs down
        stall_left = $urandom_range(0, 2);
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  // offer one request, maybe after a short gap, and return at the edge that takes it;
  // valid stays up so that a following request goes out back to back
  task automatic send_req(req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    placements_due.push_back(place_rect(r));
    reqs_sent++;
  endtask

  task automatic alloc(int unsigned w, int unsigned h);
    send_req(make_req(ReqAlloc, w, h));
  endtask

  task automatic clear_page();
    send_req(make_req(ReqClear, $urandom_range(0, 1023), $urandom_range(0, 1023)));
  endtask

  // drop valid and wait until every result is back and the block has settled
  task automatic wait_idle();
    req_valid_i <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // both config registers, written back to back while the block is idle
  task automatic set_page_size(int unsigned w, int unsigned h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgIdxWidth;
    cfg_wdata_i <= SideW'(w);
    @(posedge clk_i);
    cfg_w = w & 32'h1fff;
    cfg_idx_i   <= CfgIdxHeight;
    cfg_wdata_i <= SideW'(h);
    @(posedge clk_i);
    cfg_h = h & 32'h1fff;
    cfg_we_i    <= 1'b0;
  endtask

  // page as it comes out of reset: hits, zero sizes, doubling, refusal by size
  task automatic test_reset_page();
    alloc(10, 10);        // opens the first row at the top
    alloc(10, 8);         // lands beside it on the same row
    alloc(0, 0);          // zero-height row
    alloc(0, 0);          // and a zero-size rectangle onto it
    alloc(1023, 1023);    // one doubling is not enough
    alloc(128, 5);        // full page width forces a doubling
    alloc(1, 1);
    clear_page();
    alloc(5, 1);
  endtask

  // out-of-range config sides are clamped at the clear
  task automatic test_side_clamp();
    wait_idle();
    set_page_size(0, 8191);
    clear_page();
    alloc(16, 1);         // needs doubling past the maximum height
    alloc(15, 1);
    wait_idle();
    set_page_size(8191, 0);
    clear_page();
    alloc(3, 15);         // row reaches the bottom, doubling refused
    alloc(3, 13);
    wait_idle();
    set_page_size(16, 16);
    clear_page();
    alloc(20, 20);        // placed after doubling to 32 x 32
    alloc(1, 1023);       // still too small after one doubling
  endtask

  // tallest rectangles at the maximum side share one row, then a lower one opens a second row
  task automatic test_page_limit();
    wait_idle();
    set_page_size(4096, 4096);
    clear_page();
    repeat (4) alloc(1023, 1023);
    alloc(1023, 600);
  endtask

  // every row wider than half the page so each request opens a row until the table is full
  task automatic test_table_full();
    wait_idle();
    set_page_size(1024, 4096);
    clear_page();
    repeat (MaxShelves) alloc($urandom_range(513, 1023), $urandom_range(0, 50));
    alloc(600, 40);
    alloc(1, $urandom_range(0, 50));
    alloc(1023, 1);
  endtask

  // receiver stops for a long stretch while requests keep coming, so the block backs up
  task automatic test_long_stall();
    wait_idle();
    idle_on  <= 1'b1;
    set_page_size(2048, 2048);
    clear_page();
    hold_tgl <= ~hold_tgl;
    repeat (30) send_req(rand_rect(40));
  endtask

  // phases with a fresh page size each, random sizes around a drifting row height
  task automatic test_random_phases(int unsigned n_items);
    int unsigned stop_at, n, base;
    req_t        r;
    stop_at = reqs_sent + n_items;
    while (reqs_sent < stop_at) begin
      wait_idle();
      idle_on <= ($urandom_range(0, 4) != 0);
      set_page_size(pick_side(), pick_side());
      clear_page();
      n    = $urandom_range(15, 45);
      base = $urandom_range(1, 120);
      repeat (n) begin
        r = rand_rect(base);
        if ($urandom_range(0, 59) == 0) r.req_type = ReqClear;
        if ($urandom_range(0, 7) == 0) base = $urandom_range(1, 120);
        send_req(r);
      end
    end
  endtask

  // last stretch with no idling on either side
  task automatic test_quiet_tail();
    int unsigned base;
    wait_idle();
    idle_on <= 1'b0;
    set_page_size(pick_side(), pick_side());
    clear_page();
    base = $urandom_range(1, 80);
    repeat (40) send_req(rand_rect(base));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_page();
    test_side_clamp();
    test_page_limit();
    test_table_full();
    test_long_stall();
    test_random_phases(360);
    test_quiet_tail();

    // all results back, then room for a full row scan before closing
    wait_idle();
    repeat (MaxShelves + 16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/saa_pkg.sv
design/saa_shelf_ram.sv
design/saa_ctrl.sv
design/shelf_atlas_allocator.sv
tb/shelf_atlas_allocator_tb.sv
